/* rtl/core/pdq_pkg.sv */
// shared types, constants and error arithmetic of the palette dither quantizer
package pdq_pkg;

    // geometry and palette limits
    localparam int MAX_WIDTH     = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int PAL_CNT_W     = PAL_AW + 1;

    // register widths
    localparam int CFG_SIZE_W   = 9;
    localparam int CFG_WIDTH_W  = 13;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int WID_W        = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd3;

    // register reset values
    localparam logic [CFG_SIZE_W-1:0]   RST_PALETTE_SIZE = 9'd2;
    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // error fixed point: 8 fractional bits, stored values 20 bits
    localparam int ERR_W = 20;
    localparam int V_W   = 23;
    localparam logic signed [ERR_W-1:0] ERR_MAX_V = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN_V = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [V_W:0] SUM_MAX = {{(V_W+1-ERR_W){1'b0}}, ERR_MAX_V};
    localparam logic signed [V_W:0] SUM_MIN = {{(V_W+1-ERR_W){1'b1}}, ERR_MIN_V};

    // diffusion weights in sixteenths
    localparam logic [2:0] W_RIGHT       = 3'd7;
    localparam logic [2:0] W_BELOW_LEFT  = 3'd3;
    localparam logic [2:0] W_BELOW       = 3'd5;
    localparam logic [2:0] W_BELOW_RIGHT = 3'd1;

    typedef struct packed {
        logic       mode;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic [7:0] pixel;
    } in_word_t;

    typedef struct packed {
        logic [7:0] color_index;
        logic [7:0] color_value;
        logic       frame_end;
    } out_word_t;

    // search request and answer between the sequencer and the search unit
    typedef struct packed {
        logic                  start;
        logic [PAL_CNT_W-1:0]  count;
        logic signed [V_W-1:0] level;
    } srch_req_t;

    typedef struct packed {
        logic              done;
        logic [PAL_AW-1:0] index;
        logic [7:0]        level;
    } srch_rsp_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [7:0]        level;
    } pal_wr_t;

    function automatic logic signed [V_W-1:0] err_ext(input logic signed [ERR_W-1:0] e);
        return {{(V_W-ERR_W){e[ERR_W-1]}}, e};
    endfunction

    // floor((e * c) / 16)
    function automatic logic signed [V_W-1:0] err_share(input logic signed [V_W-1:0] e,
                                                        input logic [2:0] c);
        logic signed [V_W+2:0] p;
        p = e * $signed({1'b0, c});
        return V_W'(p >>> 4);
    endfunction

    function automatic logic signed [ERR_W-1:0] err_sat(input logic signed [V_W:0] s);
        if (s > SUM_MAX)
        begin
            return ERR_MAX_V;
        end
        else if (s < SUM_MIN)
        begin
            return ERR_MIN_V;
        end
        return s[ERR_W-1:0];
    endfunction

    // saturating add of a stored error and a share
    function automatic logic signed [ERR_W-1:0] err_acc(input logic signed [ERR_W-1:0] a,
                                                      input logic signed [V_W-1:0] sh);
        logic signed [V_W:0] s;
        s = {{(V_W+1-ERR_W){a[ERR_W-1]}}, a} + {sh[V_W-1], sh};
        return err_sat(s);
    endfunction

endpackage

/* rtl/core/palette_dither_quantizer_core.sv */
// top level: sequencer, error line memory and diffusion of the palette dither quantizer
// palette load words go straight into the palette store and give no result
// a pixel is taken only once the previous pixel's result has been loaded for output
// the palette search walks one entry per cycle
// a frame's first pixel waits while the error line is zeroed,
// when it was written since the last sweep; reset schedules that sweep too
module palette_dither_quantizer_core
    import pdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_word_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_word_t             result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // one-hot sequencer
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_CLEAR  = 10'b0000000010,
        ST_RD_X   = 10'b0000000100,
        ST_RD_XM1 = 10'b0000001000,
        ST_CALC   = 10'b0000010000,
        ST_SEARCH = 10'b0000100000,
        ST_ERR    = 10'b0001000000,
        ST_WR_XM1 = 10'b0010000000,
        ST_WR_X   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_SIZE_W-1:0]   palette_size_reg;
    logic                    dither_enable_reg;
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_HEIGHT_W-1:0] image_height_reg;

    // frame position and carried error
    logic [COL_W-1:0]        column_reg, column_next;
    logic [CFG_HEIGHT_W-1:0] row_reg, row_next;
    logic signed [ERR_W-1:0] right_carry_reg, right_carry_next;
    logic signed [ERR_W-1:0] below_carry_reg, below_carry_next;
    logic                    dirty_reg, dirty_next;
    logic [COL_W-1:0]        clr_cnt_reg, clr_cnt_next;

    // per-pixel working values
    logic [7:0]              pixel_reg, pixel_next;
    logic signed [ERR_W-1:0] err_x_reg, err_x_next;
    logic signed [ERR_W-1:0] err_xm1_reg, err_xm1_next;
    logic signed [V_W-1:0]   v_reg, v_next;
    logic signed [V_W-1:0]   err_reg, err_next;

    // output register
    logic                    result_valid_reg, result_valid_next;
    out_word_t               result_reg, result_next;

    // error line memory port
    logic                    err_we;
    logic [COL_W-1:0]        err_waddr;
    logic [ERR_W-1:0]        err_wdata;
    logic [COL_W-1:0]        err_raddr;
    logic [ERR_W-1:0]        err_rdata;

    srch_req_t               srch_req;
    srch_rsp_t               srch_rsp;
    pal_wr_t                 pal_wr;

    logic                    accept;
    logic                    frame_start;
    logic [PAL_CNT_W-1:0]    n_eff;
    logic [WID_W-1:0]        w_eff;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic                    last_col;
    logic                    last_row;
    logic                    dith;
    logic                    load_out;
    logic signed [V_W-1:0]   sh_right;
    logic signed [V_W-1:0]   sh_below_left;
    logic signed [V_W-1:0]   sh_below;
    logic signed [V_W-1:0]   sh_below_right;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg  <= RST_PALETTE_SIZE;
            dither_enable_reg <= 1'b0;
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PALETTE_SIZE:  palette_size_reg  <= cfg_data[CFG_SIZE_W-1:0];
                CFG_DITHER_ENABLE: dither_enable_reg <= cfg_data[0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and palette size
    always_comb
    begin
        if (palette_size_reg == '0)
        begin
            n_eff = PAL_CNT_W'(1);
        end
        else if (palette_size_reg > CFG_SIZE_W'(PALETTE_DEPTH))
        begin
            n_eff = PAL_CNT_W'(PALETTE_DEPTH);
        end
        else
        begin
            n_eff = PAL_CNT_W'(palette_size_reg);
        end

        if (image_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (WID_W'(image_width_reg) > WID_W'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(image_width_reg);
        end

        h_eff = (image_height_reg == '0) ? CFG_HEIGHT_W'(1) : image_height_reg;
    end

    // a column or row at or past the bound ends the row or frame
    assign last_col    = (WID_W'(column_reg) + WID_W'(1)) >= w_eff;
    assign last_row    = ((CFG_HEIGHT_W+1)'(row_reg) + (CFG_HEIGHT_W+1)'(1))
                         >= (CFG_HEIGHT_W+1)'(h_eff);
    assign dith        = dither_enable_reg;
    assign frame_start = (column_reg == '0) && (row_reg == '0);

    assign item_stall  = (state_reg != ST_IDLE);
    assign accept      = item_valid && !item_stall;

    // palette loads go straight into the palette store; slots past the depth are dropped
    assign pal_wr.en    = accept && (item.mode == MODE_LOAD)
                          && ({1'b0, item.entry_index} < 9'(PALETTE_DEPTH));
    assign pal_wr.addr  = item.entry_index[PAL_AW-1:0];
    assign pal_wr.level = item.entry_value;

    assign srch_req.start = (state_reg == ST_CALC);
    assign srch_req.count = n_eff;
    assign srch_req.level = v_next;

    pdq_nearest u_nearest (
        .clk    (clk),
        .rst_n  (rst_n),
        .pal_wr (pal_wr),
        .req    (srch_req),
        .rsp    (srch_rsp)
    );

    pdq_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_err_line (
        .clk   (clk),
        .we    (err_we),
        .waddr (err_waddr),
        .wdata (err_wdata),
        .raddr (err_raddr),
        .rdata (err_rdata)
    );

    // floyd-steinberg shares of the quantization error
    assign sh_right       = err_share(err_reg, W_RIGHT);
    assign sh_below_left  = err_share(err_reg, W_BELOW_LEFT);
    assign sh_below       = err_share(err_reg, W_BELOW);
    assign sh_below_right = err_share(err_reg, W_BELOW_RIGHT);

    // output word leaves only when the register is free or being drained
    assign load_out = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next        = state_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        right_carry_next  = right_carry_reg;
        below_carry_next  = below_carry_reg;
        dirty_next        = dirty_reg;
        clr_cnt_next      = clr_cnt_reg;
        pixel_next        = pixel_reg;
        err_x_next        = err_x_reg;
        err_xm1_next      = err_xm1_reg;
        v_next            = v_reg;
        err_next          = err_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        err_we    = 1'b0;
        err_waddr = column_reg;
        err_wdata = '0;
        err_raddr = column_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.mode == MODE_PIXEL)
                begin
                    pixel_next = item.pixel;
                    if (frame_start)
                    begin
                        // new frame: carries drop, line memory swept if touched
                        right_carry_next = '0;
                        below_carry_next = '0;
                        state_next       = dirty_reg ? ST_CLEAR : ST_RD_X;
                    end
                    else
                    begin
                        state_next = ST_RD_X;
                    end
                end
            end
            ST_CLEAR:
            begin
                err_we       = 1'b1;
                err_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + COL_W'(1);
                if (clr_cnt_reg == COL_W'(MAX_WIDTH - 1))
                begin
                    clr_cnt_next = '0;
                    dirty_next   = 1'b0;
                    state_next   = ST_RD_X;
                end
            end
            ST_RD_X:
            begin
                err_raddr  = column_reg;
                state_next = ST_RD_XM1;
            end
            ST_RD_XM1:
            begin
                // entry left of x; at column 0 the word read is unused
                err_raddr  = column_reg - COL_W'(1);
                err_x_next = err_rdata;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                err_xm1_next = err_rdata;
                v_next = {{(V_W-16){1'b0}}, pixel_reg, 8'h00};
                if (dith)
                begin
                    v_next = v_next + err_ext(err_x_reg) + err_ext(right_carry_reg);
                end
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next   = v_reg - {{(V_W-16){1'b0}}, srch_rsp.level, 8'h00};
                state_next = ST_WR_XM1;
            end
            ST_WR_XM1:
            begin
                if (dith && !last_row && column_reg != '0)
                begin
                    err_we     = 1'b1;
                    err_waddr  = column_reg - COL_W'(1);
                    err_wdata  = err_acc(err_xm1_reg, sh_below_left);
                    dirty_next = 1'b1;
                end
                state_next = ST_WR_X;
            end
            ST_WR_X:
            begin
                if (dith && !last_row)
                begin
                    err_we     = 1'b1;
                    err_waddr  = column_reg;
                    err_wdata  = err_acc(below_carry_reg, sh_below);
                    dirty_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    result_valid_next       = 1'b1;
                    result_next.color_index = 8'(srch_rsp.index);
                    result_next.color_value = srch_rsp.level;
                    result_next.frame_end   = last_col && last_row;

                    if (dith)
                    begin
                        right_carry_next = err_acc('0, sh_right);
                        below_carry_next = last_row ? '0 : err_acc('0, sh_below_right);
                    end

                    // end of row drops both carries
                    if (last_col)
                    begin
                        right_carry_next = '0;
                        below_carry_next = '0;
                        column_next      = '0;
                        row_next         = last_row ? '0 : row_reg + CFG_HEIGHT_W'(1);
                    end
                    else
                    begin
                        column_next = column_reg + COL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            column_reg       <= '0;
            row_reg          <= '0;
            right_carry_reg  <= '0;
            below_carry_reg  <= '0;
            dirty_reg        <= 1'b1;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            right_carry_reg  <= right_carry_next;
            below_carry_reg  <= below_carry_next;
            dirty_reg        <= dirty_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg   <= pixel_next;
        err_x_reg   <= err_x_next;
        err_xm1_reg <= err_xm1_next;
        v_reg       <= v_next;
        err_reg     <= err_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/pdq_ram.sv */
// generic single-clock ram, one write port and one registered read port
module pdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/pdq_nearest.sv */
// palette store and nearest-entry search, one entry compared per cycle
module pdq_nearest
    import pdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pal_wr_t   pal_wr,
    input  srch_req_t req,
    output srch_rsp_t rsp
);

    localparam int DIST_W = V_W + 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PAL_CNT_W-1:0]  cmp_reg, cmp_next;
    logic [PAL_CNT_W-1:0]  count_reg, count_next;
    logic signed [V_W-1:0] level_reg, level_next;
    logic [DIST_W-1:0]     bestd_reg, bestd_next;
    logic [PAL_AW-1:0]     best_idx_reg, best_idx_next;
    logic [7:0]            best_val_reg, best_val_next;

    logic [PAL_AW-1:0]     pal_raddr;
    logic [7:0]            pal_rdata;
    logic [DIST_W-1:0]     diff;
    logic [DIST_W-1:0]     abs_diff;
    logic [PAL_CNT_W-1:0]  cmp_inc;
    logic                  last;

    pdq_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_wr.en),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.level),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    assign cmp_inc   = cmp_reg + PAL_CNT_W'(1);
    // entry 0 is fetched while idle so it is ready on the first compare
    assign pal_raddr = busy_reg ? cmp_inc[PAL_AW-1:0] : '0;
    assign diff      = {level_reg[V_W-1], level_reg}
                     - {{(DIST_W-16){1'b0}}, pal_rdata, 8'h00};
    assign abs_diff  = diff[DIST_W-1] ? (~diff + DIST_W'(1)) : diff;
    assign last      = (cmp_inc == count_reg);

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cmp_next      = cmp_reg;
        count_next    = count_reg;
        level_next    = level_reg;
        bestd_next    = bestd_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        if (busy_reg)
        begin
            // strict less keeps the lowest index on a tie
            if (cmp_reg == '0 || abs_diff < bestd_reg)
            begin
                bestd_next    = abs_diff;
                best_idx_next = cmp_reg[PAL_AW-1:0];
                best_val_next = pal_rdata;
            end
            cmp_next = cmp_inc;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next  = 1'b1;
            cmp_next   = '0;
            count_next = req.count;
            level_next = req.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cmp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cmp_reg  <= cmp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        level_reg    <= level_next;
        bestd_reg    <= bestd_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.index = best_idx_reg;
    assign rsp.level = best_val_reg;

endmodule
